// File: hdl/fjsop_pkg.sv
// shared types, codes and the byte classifier for the flat json object parser
`default_nettype none

package fjsop_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBSlash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [2:0] {
    CLS_WS,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_COLON,
    CLS_COMMA,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_OTHER
  } byte_class_e;

  typedef enum logic [2:0] {
    TK_IGNORED = 3'd0,
    TK_KEYBYTE = 3'd1,
    TK_VALBYTE = 3'd2,
    TK_KEYEND  = 3'd3,
    TK_PAIREND = 3'd4,
    TK_OBJEND  = 3'd5,
    TK_ERROR   = 3'd6
  } token_kind_e;

  typedef enum logic [2:0] {
    PH_BRACE,
    PH_KEY_END,
    PH_IN_KEY,
    PH_COLON,
    PH_VALUE,
    PH_IN_VALUE,
    PH_COMMA_END,
    PH_DONE
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        last;
    byte_class_e cls;
  } fjsop_item_t;

  function automatic byte_class_e classify(input logic [7:0] c);
    byte_class_e cls;
    cls = CLS_OTHER;
    if (c == ChSpace || c inside {[ChTab:ChCr]}) begin
      cls = CLS_WS;
    end else begin
      case (c)
        ChLBrace: cls = CLS_LBRACE;
        ChRBrace: cls = CLS_RBRACE;
        ChColon:  cls = CLS_COLON;
        ChComma:  cls = CLS_COMMA;
        ChQuote:  cls = CLS_QUOTE;
        ChBSlash: cls = CLS_BSLASH;
        default:  cls = CLS_OTHER;
      endcase
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// File: hdl/fjsop_front.sv
// front stage: takes input beats and tags each byte with its class
`default_nettype none

module fjsop_front import fjsop_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        end_of_text_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output fjsop_item_t      push_item_o
);

  logic        valid_q, valid_d;
  fjsop_item_t item_q;
  logic        take;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.text_byte <= text_byte_i;
      item_q.last      <= end_of_text_i;
      item_q.cls       <= classify(text_byte_i);
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

`default_nettype wire

// File: hdl/fjsop_fifo.sv
// short queue between the classifier and the parser state machine
`default_nettype none

module fjsop_fifo import fjsop_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output logic        push_ready_o,
  input  wire fjsop_item_t push_item_i,
  output logic        pop_valid_o,
  input  wire logic   pop_ready_i,
  output fjsop_item_t pop_item_o
);

  fjsop_item_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0]    wptr_q, wptr_d;
  logic [FifoPtrW-1:0]    rptr_q, rptr_d;
  logic [FifoCntW-1:0]    count_q, count_d;
  logic                   push, pop;

  assign push_ready_o = count_q != FifoCntW'(FifoDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/fjsop_back.sv
// back stage: parser state machine and registered result beat
`default_nettype none

module fjsop_back import fjsop_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_valid_i,
  output logic             pop_ready_o,
  input  wire fjsop_item_t pop_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       token_kind_o,
  output logic [7:0]       payload_byte_o
);

  parse_phase_e phase_q, phase_d;
  logic         esc_q, esc_d;
  logic         out_valid_q, out_valid_d;
  token_kind_e  kind_q, kind;
  logic [7:0]   byte_q;
  logic         take;
  logic         was_done;
  token_kind_e  body_kind, end_kind;
  parse_phase_e close_phase;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;
  assign was_done    = phase_q == PH_DONE;

  always_comb begin
    phase_d     = phase_q;
    esc_d       = esc_q;
    kind        = TK_IGNORED;
    body_kind   = (phase_q == PH_IN_KEY) ? TK_KEYBYTE : TK_VALBYTE;
    end_kind    = (phase_q == PH_IN_KEY) ? TK_KEYEND : TK_PAIREND;
    close_phase = (phase_q == PH_IN_KEY) ? PH_COLON : PH_COMMA_END;
    case (phase_q)
      PH_DONE: begin
        kind = TK_IGNORED;
      end
      PH_IN_KEY, PH_IN_VALUE: begin
        kind = body_kind;
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (pop_item_i.cls == CLS_BSLASH) begin
          esc_d = 1'b1;
        end else if (pop_item_i.cls == CLS_QUOTE) begin
          phase_d = close_phase;
          kind    = end_kind;
        end
      end
      default: begin
        if (pop_item_i.cls != CLS_WS) begin
          case (phase_q)
            PH_BRACE: begin
              if (pop_item_i.cls == CLS_LBRACE) phase_d = PH_KEY_END;
              else kind = TK_ERROR;
            end
            PH_KEY_END: begin
              if (pop_item_i.cls == CLS_RBRACE) begin
                kind = TK_OBJEND;
              end else if (pop_item_i.cls == CLS_QUOTE) begin
                phase_d = PH_IN_KEY;
                esc_d   = 1'b0;
              end else begin
                kind = TK_ERROR;
              end
            end
            PH_COLON: begin
              if (pop_item_i.cls == CLS_COLON) phase_d = PH_VALUE;
              else kind = TK_ERROR;
            end
            PH_VALUE: begin
              if (pop_item_i.cls == CLS_QUOTE) begin
                phase_d = PH_IN_VALUE;
                esc_d   = 1'b0;
              end else begin
                kind = TK_ERROR;
              end
            end
            default: begin
              if (pop_item_i.cls == CLS_COMMA) phase_d = PH_KEY_END;
              else if (pop_item_i.cls == CLS_RBRACE) kind = TK_OBJEND;
              else kind = TK_ERROR;
            end
          endcase
          if (kind == TK_OBJEND || kind == TK_ERROR) begin
            phase_d = PH_DONE;
            esc_d   = 1'b0;
          end
        end
      end
    endcase
    if (pop_item_i.last) begin
      if (!was_done && kind != TK_OBJEND) begin
        kind = TK_ERROR;
      end
      phase_d = PH_BRACE;
      esc_d   = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BRACE;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q <= phase_d;
        esc_q   <= esc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind;
      byte_q <= (kind == TK_KEYBYTE || kind == TK_VALBYTE) ? pop_item_i.text_byte : 8'h00;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = kind_q;
  assign payload_byte_o = byte_q;

endmodule

`default_nettype wire

// File: hdl/flat_json_string_object_parser.sv
// top level of the flat json string object parser
//
//   channel | direction | beat fields
//   in      | input     | text_byte_i, end_of_text_i
//   out     | output    | token_kind_o, payload_byte_o
//
// one beat in and one beat out per cycle sustained while out_ready_i stays high
// a result beat passes through the front register, the queue and the output register in that order
// front register and output register hold one beat each, the queue two
// reset puts the parser in the expect-opening-brace phase with all stages empty
// a stalled output fills the queue before in_ready_o drops
`default_nettype none

module flat_json_string_object_parser import fjsop_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      token_kind_o,
  output logic [7:0]      payload_byte_o
);

  logic        push_valid, push_ready;
  fjsop_item_t push_item;
  logic        pop_valid, pop_ready;
  fjsop_item_t pop_item;

  fjsop_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  fjsop_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  fjsop_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .payload_byte_o (payload_byte_o)
  );

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != TK_KEYBYTE && token_kind_o != TK_VALBYTE
      |-> payload_byte_o == 8'h00)
    else $error("payload not zero on non-string beat");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o != 3'd7)
    else $error("token kind out of range");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready |-> pop_valid)
    else $error("queue full and empty at once");

  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> push_valid && !push_ready && out_valid_o)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
